// ===== hdl/otsr_pkg.sv =====
// Package for the outlined text strip renderer.
// Holds the font, the glyph geometry, the register indexes and the default sizes.
// No dependencies.
package otsr_pkg;

  // Default sizes of the strip and of the text.
  localparam int MaxCharsDefault   = 9;
  localparam int StripWidthDefault = 55;
  localparam int StripHeight       = 11;

  // Glyph geometry: a 5x7 cell, one blank column between glyphs, 2-pixel pad.
  localparam int GlyphW  = 5;
  localparam int GlyphH  = 7;
  localparam int Advance = 6;
  localparam int Pad     = 2;

  // Pixel levels. The outline alpha is 0.85 of full scale, rounded.
  localparam logic [7:0] LevelFull    = 8'd255;
  localparam logic [7:0] OutlineAlpha = 8'd217;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_CHAR_COUNT = 2'd0,
    CFG_TEXT_LOW   = 2'd1,
    CFG_TEXT_LAST  = 2'd2
  } cfg_reg_e;

  // One glyph: row 0 first, bit 4 of a row is the leftmost column.
  typedef logic [0:GlyphH-1][GlyphW-1:0] glyph_t;

  // Font lookup. Characters that the font does not hold come back blank.
  function automatic glyph_t font_glyph(input logic [7:0] code);
    glyph_t g;
    case (code)
      8'h30:   g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
      8'h31:   g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      8'h32:   g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
      8'h33:   g = {5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E};
      8'h34:   g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
      8'h35:   g = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E};
      8'h36:   g = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
      8'h37:   g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
      8'h38:   g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      8'h39:   g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
      8'h2E:   g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C};
      8'h46:   g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
      8'h50:   g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
      8'h53:   g = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

// ===== hdl/outlined_text_strip_renderer.sv =====
// Outlined text strip renderer: one pixel of a 5x7 text strip with outline per request.
// Depends on otsr_pkg for the font, the geometry and the register indexes.

// A new coordinate is taken in every clock cycle (busy stays low). Its pixel
// appears on the result ports, marked by valid_o, after it has passed the
// four register stages: column split, character select, font lookup, and the
// outline merge that feeds the output register. The receiver cannot stall, so
// each result is shown for one cycle only. Configuration may be written
// only while no pixel is in flight.
module outlined_text_strip_renderer
  import otsr_pkg::*;
#(
  parameter int MAX_CHARS   = MaxCharsDefault,
  parameter int STRIP_WIDTH = StripWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Pixel request
  input  logic        start,
  output logic        busy,
  input  logic [5:0]  pixel_x_i,
  input  logic [3:0]  pixel_y_i,
  // Pixel result
  output logic        valid_o,
  output logic [7:0]  gray_level_o,
  output logic [7:0]  opacity_o,
  output logic [5:0]  text_span_o,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_wdata_i
);

  localparam logic [6:0] StripW7    = 7'(STRIP_WIDTH);
  localparam logic [3:0] MaxChars4  = 4'(MAX_CHARS);
  localparam logic [3:0] StripH4    = 4'(StripHeight);
  localparam logic [4:0] RowFirst   = 5'(Pad);
  localparam logic [4:0] RowEnd     = 5'(Pad + GlyphH);
  localparam logic [6:0] Pad7       = 7'(Pad);
  localparam logic [2:0] GlyphW3    = 3'(GlyphW);
  localparam logic [2:0] GlyphLast  = 3'(GlyphW - 1);
  localparam logic [5:0] Advance6   = 6'(Advance);

  // Configuration registers.
  logic [3:0]  char_count_q;
  logic [63:0] text_low_q;
  logic [7:0]  text_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_count_q <= '0;
      text_low_q   <= '0;
      text_last_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_CHAR_COUNT: char_count_q <= cfg_wdata_i[3:0];
        CFG_TEXT_LOW:   text_low_q   <= cfg_wdata_i;
        CFG_TEXT_LAST:  text_last_q  <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Effective character count and the width that the text covers.
  logic [3:0] cnt_eff;
  logic [6:0] used_full;
  logic [5:0] text_span_d;

  always_comb begin
    cnt_eff     = (char_count_q > MaxChars4) ? MaxChars4 : char_count_q;
    used_full   = 7'(cnt_eff) * 7'(Advance) + 7'd3;
    text_span_d = 6'((used_full > StripW7) ? StripW7 : used_full);
  end

  // The pipeline always takes a new request.
  assign busy = 1'b0;

  // Stage 1: neighbour columns split into slot and glyph column, neighbour rows.
  logic             v1_q, in_strip1_q;
  logic [2:0]       colok1_q, rowok1_q;
  logic [3:0]       slot1_q [3];
  logic [2:0]       gx1_q   [3];
  logic [2:0]       row1_q  [3];

  logic             in_strip1_d;
  logic [2:0]       colok1_d, rowok1_d;
  logic [3:0]       slot1_d [3];
  logic [2:0]       gx1_d   [3];
  logic [2:0]       row1_d  [3];

  always_comb begin
    logic [6:0]  nx;
    logic [6:0]  col;
    logic [11:0] prod;
    logic [4:0]  ny;
    logic [4:0]  rr;
    in_strip1_d = (7'(pixel_x_i) < StripW7) && (pixel_y_i < StripH4);
    for (int d = 0; d < 3; d++) begin
      // Column x + d - 1; a step left of column 0 wraps high and fails the bound.
      nx          = 7'(pixel_x_i) + 7'(d) - 7'd1;
      col         = nx - Pad7;
      colok1_d[d] = (nx < StripW7) && (nx >= Pad7);
      // Division by the advance through a reciprocal, exact for columns below 64.
      prod        = 12'(col[5:0]) * 12'd43;
      slot1_d[d]  = prod[11:8];
      gx1_d[d]    = 3'(col[5:0] - 6'(slot1_d[d]) * Advance6);
      // Row y + d - 1 inside the glyph band.
      ny          = 5'(pixel_y_i) + 5'(d) - 5'd1;
      rr          = ny - RowFirst;
      rowok1_d[d] = (ny >= RowFirst) && (ny < RowEnd);
      row1_d[d]   = rr[2:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    in_strip1_q <= in_strip1_d;
    colok1_q    <= colok1_d;
    rowok1_q    <= rowok1_d;
    slot1_q     <= slot1_d;
    gx1_q       <= gx1_d;
    row1_q      <= row1_d;
  end

  // Stage 2: pick the character of each neighbour column.
  logic             v2_q, in_strip2_q;
  logic [2:0]       colok2_q, rowok2_q;
  logic [7:0]       code2_q [3];
  logic [2:0]       gx2_q   [3];
  logic [2:0]       row2_q  [3];

  logic [2:0]       colok2_d;
  logic [7:0]       code2_d [3];

  always_comb begin
    for (int d = 0; d < 3; d++) begin
      colok2_d[d] = colok1_q[d] && (gx1_q[d] < GlyphW3) && (slot1_q[d] < cnt_eff);
      code2_d[d]  = slot1_q[d][3] ? text_last_q : text_low_q[8*slot1_q[d][2:0] +: 8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    in_strip2_q <= in_strip1_q;
    colok2_q    <= colok2_d;
    rowok2_q    <= rowok1_q;
    code2_q     <= code2_d;
    gx2_q       <= gx1_q;
    row2_q      <= row1_q;
  end

  // Stage 3: font lookup, keeping the one glyph column that each neighbour uses.
  logic             v3_q, in_strip3_q;
  logic [2:0]       rowok3_q;
  logic [GlyphH-1:0] colbits3_q [3];
  logic [2:0]       row3_q  [3];

  logic [GlyphH-1:0] colbits3_d [3];

  always_comb begin
    glyph_t     g;
    logic [2:0] bit_sel;
    for (int d = 0; d < 3; d++) begin
      g       = font_glyph(code2_q[d]);
      bit_sel = GlyphLast - gx2_q[d];
      for (int r = 0; r < GlyphH; r++) begin
        colbits3_d[d][r] = colok2_q[d] && g[r][bit_sel];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    in_strip3_q <= in_strip2_q;
    rowok3_q    <= rowok2_q;
    colbits3_q  <= colbits3_d;
    row3_q      <= row2_q;
  end

  // Stage 4: merge the 3x3 neighbourhood into core, outline or transparent.
  logic       valid_q;
  logic [7:0] gray_level_q, opacity_q;
  logic [5:0] text_span_q;
  logic [7:0] gray_level_d, opacity_d;

  always_comb begin
    logic [2:0][2:0] cov;
    for (int dy = 0; dy < 3; dy++) begin
      for (int dx = 0; dx < 3; dx++) begin
        cov[dy][dx] = rowok3_q[dy] && colbits3_q[dx][row3_q[dy]];
      end
    end
    gray_level_d = '0;
    opacity_d    = '0;
    if (in_strip3_q) begin
      if (cov[1][1]) begin
        gray_level_d = LevelFull;
        opacity_d    = LevelFull;
      end else if (|cov) begin
        opacity_d    = OutlineAlpha;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    gray_level_q <= gray_level_d;
    opacity_q    <= opacity_d;
    text_span_q  <= text_span_d;
  end

  assign valid_o      = valid_q;
  assign gray_level_o = gray_level_q;
  assign opacity_o    = opacity_q;
  assign text_span_o  = text_span_q;

endmodule
